// File: rtl/gsma_pkg.sv
package gsma_pkg;

  localparam int unsigned MAX_LANES = 4;
  localparam int unsigned FEAT_W    = 16;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned DEG_W     = 16;
  localparam int unsigned NODE_W    = 8;
  localparam int unsigned CFG_W     = 9;

  localparam logic REQ_ACC  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_UPDATE,
    S_DIV,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic load_req;
    logic wr_acc;
    logic div_start;
    logic div_step;
    logic rd_clear;
    logic out_load;
    logic out_reject;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic req_ok;
    logic req_read;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

// File: rtl/gsma_if.sv
interface gsma_in_if;
  import gsma_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [NODE_W-1:0]        node;
  logic signed [FEAT_W-1:0] feat_0;
  logic signed [FEAT_W-1:0] feat_1;
  logic signed [FEAT_W-1:0] feat_2;
  logic signed [FEAT_W-1:0] feat_3;
  modport source (output valid, req_type, node, feat_0, feat_1, feat_2, feat_3, input ready);
  modport sink   (input valid, req_type, node, feat_0, feat_1, feat_2, feat_3, output ready);
endinterface

interface gsma_out_if;
  import gsma_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [NODE_W-1:0]        node_out;
  logic signed [FEAT_W-1:0] mean_0;
  logic signed [FEAT_W-1:0] mean_1;
  logic signed [FEAT_W-1:0] mean_2;
  logic signed [FEAT_W-1:0] mean_3;
  logic [DEG_W-1:0]         degree;
  logic                     status;
  modport source (output valid, node_out, mean_0, mean_1, mean_2, mean_3, degree, status,
                  input ready);
  modport sink   (input valid, node_out, mean_0, mean_1, mean_2, mean_3, degree, status,
                  output ready);
endinterface

interface gsma_cfg_if;
  import gsma_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/gsma_ctrl.sv
module gsma_ctrl
  import gsma_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_FETCH;
        end
      end
      S_FETCH: begin
        // memory read data lands at end of this cycle
        if (!stat.req_ok && !stat.req_read) begin
          state_nxt = S_IDLE;
        end else if (!stat.req_ok) begin
          state_nxt = S_OUT;
        end else if (stat.req_read) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.wr_acc = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load   = 1'b1;
          cmd.out_reject = !stat.req_ok;
          cmd.rd_clear   = stat.req_ok;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.div_start = (state_r == S_FETCH);
  end

endmodule

// File: rtl/gsma_dp.sv
module gsma_dp
  import gsma_pkg::*;
#(
  parameter int unsigned LANES = 4,
  parameter int unsigned NODES = 256
)(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [CFG_W-1:0] active_nodes,
  gsma_in_if.sink          in_ch,
  gsma_out_if.source       out_ch
);

  localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned RW = LANES * SUM_W + DEG_W;
  localparam int unsigned DVW = SUM_W + DEG_W + 1;

  // one row per node: LANES sums then degree
  logic [RW-1:0] mem [NODES];
  logic [RW-1:0] rd_data_r;

  logic [AW:0]       clr_cnt_r;
  logic              req_read_r, req_ok_r;
  logic [NODE_W-1:0] node_r;
  logic signed [FEAT_W-1:0] feat_r [MAX_LANES];

  logic [AW-1:0] addr;
  logic          we;
  logic [RW-1:0] wdata;
  logic [AW-1:0] rd_addr;

  assign rd_addr = node_r[AW-1:0];

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step && !clr_cnt_r[AW]) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end
  assign stat.clr_done = (clr_cnt_r == (AW+1)'(NODES - 1)) || clr_cnt_r[AW];

  // request capture
  logic [CFG_W-1:0] limit;
  assign limit = (active_nodes < CFG_W'(NODES)) ? active_nodes : CFG_W'(NODES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_read_r <= 1'b0;
      req_ok_r   <= 1'b0;
    end else if (cmd.load_req) begin
      req_read_r <= (in_ch.req_type == REQ_READ);
      req_ok_r   <= {1'b0, in_ch.node} < limit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      node_r    <= in_ch.node;
      feat_r[0] <= in_ch.feat_0;
      feat_r[1] <= in_ch.feat_1;
      feat_r[2] <= in_ch.feat_2;
      feat_r[3] <= in_ch.feat_3;
    end
  end

  assign stat.req_ok   = req_ok_r;
  assign stat.req_read = req_read_r;

  // accumulate row
  logic [RW-1:0] acc_row;
  always_comb begin
    logic signed [SUM_W:0] s;
    logic [DEG_W-1:0] d;
    acc_row = rd_data_r;
    for (int c = 0; c < LANES; c++) begin
      s = $signed(rd_data_r[c*SUM_W +: SUM_W]) + (SUM_W+1)'(feat_r[c]);
      if (s[SUM_W] != s[SUM_W-1]) begin
        acc_row[c*SUM_W +: SUM_W] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                             : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        acc_row[c*SUM_W +: SUM_W] = s[SUM_W-1:0];
      end
    end
    d = rd_data_r[LANES*SUM_W +: DEG_W];
    acc_row[LANES*SUM_W +: DEG_W] = (d == {DEG_W{1'b1}}) ? d : d + 1'b1;
  end

  always_comb begin
    we    = 1'b0;
    addr  = rd_addr;
    wdata = '0;
    if (cmd.clr_step && !clr_cnt_r[AW]) begin
      we   = 1'b1;
      addr = clr_cnt_r[AW-1:0];
    end else if (cmd.wr_acc) begin
      we    = 1'b1;
      wdata = acc_row;
    end else if (cmd.rd_clear) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // shared restoring divider: one quotient bit per cycle, lanes in turn
  logic [1:0]          lane_r;
  logic [5:0]          bit_r;
  logic                div_busy_r;
  logic [SUM_W-1:0]    quo_r;
  logic [DVW-1:0]      rem_r;
  logic                neg_r;
  logic [DEG_W-1:0]    deg;
  logic signed [FEAT_W-1:0] mean_r [MAX_LANES];
  logic [SUM_W-1:0]    dividend;
  logic signed [SUM_W-1:0] cur_sum;
  logic [DVW-1:0]      trial;
  logic [DVW-1:0]      sh;

  assign deg     = rd_data_r[LANES*SUM_W +: DEG_W];
  assign cur_sum = $signed(rd_data_r[lane_r*SUM_W +: SUM_W]);
  assign dividend = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : cur_sum;
  assign sh    = {rem_r[DVW-2:0], quo_r[SUM_W-1]};
  assign trial = sh - DVW'(deg);

  assign stat.div_done = div_busy_r && (bit_r == 6'd0) &&
                         (lane_r == 2'(LANES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b0;
      lane_r     <= '0;
      bit_r      <= 6'(SUM_W);
    end else if (cmd.div_step) begin
      if (!div_busy_r) begin
        div_busy_r <= 1'b1;
        quo_r      <= dividend;
        rem_r      <= '0;
        neg_r      <= cur_sum[SUM_W-1];
        bit_r      <= 6'(SUM_W);
      end else if (bit_r != 6'd0) begin
        if (!trial[DVW-1]) begin
          rem_r <= trial;
          quo_r <= {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_r <= sh;
          quo_r <= {quo_r[SUM_W-2:0], 1'b0};
        end
        bit_r <= bit_r - 1'b1;
      end else begin
        div_busy_r <= 1'b0;
        lane_r     <= lane_r + 1'b1;
      end
    end
  end

  // signed saturate of finished quotient
  always_ff @(posedge clk) begin
    logic signed [SUM_W:0] q;
    if (cmd.div_start) begin
      for (int c = 0; c < MAX_LANES; c++) begin
        mean_r[c] <= '0;
      end
    end else if (cmd.div_step && div_busy_r && bit_r == 6'd0) begin
      q = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
      if (deg == '0) begin
        mean_r[lane_r] <= '0;
      end else if (q > 32767) begin
        mean_r[lane_r] <= 16'sh7FFF;
      end else if (q < -32768) begin
        mean_r[lane_r] <= 16'sh8000;
      end else begin
        mean_r[lane_r] <= q[FEAT_W-1:0];
      end
    end
  end

  // output register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.node_out <= node_r;
      out_ch.status   <= cmd.out_reject ? ST_RANGE : ST_OK;
      out_ch.degree   <= cmd.out_reject ? '0 : deg;
      out_ch.mean_0   <= cmd.out_reject ? '0 : mean_r[0];
      out_ch.mean_1   <= cmd.out_reject ? '0 : mean_r[1];
      out_ch.mean_2   <= cmd.out_reject ? '0 : mean_r[2];
      out_ch.mean_3   <= cmd.out_reject ? '0 : mean_r[3];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign stat.out_busy = out_valid_r && !out_ch.ready;

endmodule

// File: rtl/graph_scatter_mean_aggregate.sv
// Channel | Dir | Payload
// in      | in  | req_type, node, feat_0..feat_3
// out     | out | node_out, mean_0..mean_3, degree, status
// cfg     | in  | data (active_nodes)
// Edge item: accept, row read, write back.
// Read item: accept, row read, then the shared bit-serial divider, one lane at a time.
// After reset a clearing pass wipes every row of the memory; no items
//   are taken during it, config writes are.
// The output register frees the block while a result waits, unless a second
//   result is ready before the first is taken.
module graph_scatter_mean_aggregate
  import gsma_pkg::*;
#(
  parameter int unsigned LANES = 4,
  parameter int unsigned NODES = 256
)(
  input  logic clk,
  input  logic rst_n,
  gsma_in_if.sink    in_ch,
  gsma_out_if.source out_ch,
  gsma_cfg_if.sink   cfg_ch
);

  cmd_t  cmd;
  stat_t stat;
  logic [CFG_W-1:0] active_nodes_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_nodes_r <= CFG_W'(256);
    end else if (cfg_ch.valid) begin
      active_nodes_r <= cfg_ch.data;
    end
  end

  gsma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gsma_dp #(.LANES(LANES), .NODES(NODES)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .active_nodes (active_nodes_r),
    .in_ch        (in_ch),
    .out_ch       (out_ch)
  );

endmodule

// File: tb/sv/gsma_tb_pkg.sv
package gsma_tb_pkg;
  import gsma_pkg::*;

  typedef struct packed {
    logic                     req_type;
    logic [NODE_W-1:0]        node;
    logic signed [FEAT_W-1:0] f0;
    logic signed [FEAT_W-1:0] f1;
    logic signed [FEAT_W-1:0] f2;
    logic signed [FEAT_W-1:0] f3;
  } edge_req_t;

  typedef struct packed {
    logic [NODE_W-1:0]        node_out;
    logic signed [FEAT_W-1:0] m0;
    logic signed [FEAT_W-1:0] m1;
    logic signed [FEAT_W-1:0] m2;
    logic signed [FEAT_W-1:0] m3;
    logic [DEG_W-1:0]         degree;
    logic                     status;
  } node_mean_t;

endpackage

// File: tb/sv/gsma_tb_if.sv
// Testbench-side channel bundles are the RTL interfaces themselves; this file
// only collects the helpers that fill idle bursts.
package gsma_tb_idle_pkg;
  function automatic int unsigned pick_burst();
    return $urandom_range(1, 9);
  endfunction
endpackage

// File: tb/sv/graph_scatter_mean_aggregate_tb.sv
module graph_scatter_mean_aggregate_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsma_pkg::*;
  import gsma_tb_pkg::*;
  import gsma_tb_idle_pkg::*;

  localparam int NLANES = 4;
  localparam int NNODES = 256;
  localparam int RAND_ITEMS = 1375;
  // slowest read waits on the bit-serial divider for every lane, plus stalls; generous
  localparam longint CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst_n;

  gsma_in_if  in_ch();
  gsma_out_if out_ch();
  gsma_cfg_if cfg_ch();

  graph_scatter_mean_aggregate #(.LANES(NLANES), .NODES(NNODES)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state: row sums, degrees, active node count
  logic signed [SUM_W-1:0] sum_row [NNODES][NLANES];
  logic [DEG_W-1:0]        deg_cnt [NNODES];
  logic [CFG_W-1:0]        active_cnt;

  edge_req_t  pending_q[$];
  node_mean_t mean_q[$];

  int  errors;
  bit  calm;          // no idling in the last part of the run
  int  in_gap, out_gap;
  longint cycles;

  function automatic logic signed [FEAT_W-1:0] div_sat(logic signed [SUM_W-1:0] s,
                                                        logic [DEG_W-1:0] d);
    longint q;
    if (d == 0) return '0;
    q = longint'(s) / longint'(d);  // truncates toward zero
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[FEAT_W-1:0];
  endfunction

  // apply one accepted item, queue the mean it produces if any
  task automatic apply_item(edge_req_t r);
    int lim;
    longint acc;
    logic signed [FEAT_W-1:0] f [NLANES];
    logic signed [FEAT_W-1:0] m [NLANES];
    node_mean_t res;
    f[0] = r.f0; f[1] = r.f1; f[2] = r.f2; f[3] = r.f3;
    lim = (active_cnt < NNODES) ? active_cnt : NNODES;
    if (r.req_type == REQ_ACC) begin
      if (r.node >= lim) return;
      for (int c = 0; c < NLANES; c++) begin
        acc = longint'(sum_row[r.node][c]) + longint'(f[c]);
        if (acc > 64'sh7fffffff) acc = 64'sh7fffffff;
        if (acc < -64'sh80000000) acc = -64'sh80000000;
        sum_row[r.node][c] = acc[SUM_W-1:0];
      end
      if (deg_cnt[r.node] != 16'hffff) deg_cnt[r.node]++;
      return;
    end
    res = '0;
    res.node_out = r.node;
    if (r.node >= lim) begin
      res.status = ST_RANGE;
    end else begin
      for (int c = 0; c < NLANES; c++) begin
        m[c] = div_sat(sum_row[r.node][c], deg_cnt[r.node]);
        sum_row[r.node][c] = '0;
      end
      res.m0 = m[0]; res.m1 = m[1]; res.m2 = m[2]; res.m3 = m[3];
      res.degree = deg_cnt[r.node];
      res.status = ST_OK;
      deg_cnt[r.node] = '0;
    end
    mean_q.insert(mean_q.size(), res);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_item(pending_q.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        in_gap <= pick_burst();
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
                   pending_q.size() != 0) begin
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= pending_q[0].req_type;
        in_ch.node     <= pending_q[0].node;
        in_ch.feat_0   <= pending_q[0].f0;
        in_ch.feat_1   <= pending_q[0].f1;
        in_ch.feat_2   <= pending_q[0].f2;
        in_ch.feat_3   <= pending_q[0].f3;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: compares each result with the oldest expected mean
  always @(posedge clk) begin
    node_mean_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.node_out, out_ch.mean_0, out_ch.mean_1, out_ch.mean_2,
                out_ch.mean_3, out_ch.degree, out_ch.status};
        if (mean_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual %p", $time, got);
        end else begin
          want = mean_q.pop_front();
          if (got.node_out !== want.node_out)
            begin errors++; $display("%0t node_out expected %0d actual %0d", $time,
                                     want.node_out, got.node_out); end
          if (got.m0 !== want.m0)
            begin errors++; $display("%0t mean_0 expected %0d actual %0d", $time,
                                     want.m0, got.m0); end
          if (got.m1 !== want.m1)
            begin errors++; $display("%0t mean_1 expected %0d actual %0d", $time,
                                     want.m1, got.m1); end
          if (got.m2 !== want.m2)
            begin errors++; $display("%0t mean_2 expected %0d actual %0d", $time,
                                     want.m2, got.m2); end
          if (got.m3 !== want.m3)
            begin errors++; $display("%0t mean_3 expected %0d actual %0d", $time,
                                     want.m3, got.m3); end
          if (got.degree !== want.degree)
            begin errors++; $display("%0t degree expected %0d actual %0d", $time,
                                     want.degree, got.degree); end
          if (got.status !== want.status)
            begin errors++; $display("%0t status expected %0d actual %0d", $time,
                                     want.status, got.status); end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_gap <= pick_burst();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic edge_req_t mk(logic rt, logic [7:0] n, logic [15:0] a,
                                   logic [15:0] b, logic [15:0] c, logic [15:0] d);
    edge_req_t r;
    r.req_type = rt; r.node = n; r.f0 = a; r.f1 = b; r.f2 = c; r.f3 = d;
    return r;
  endfunction

  // append one item to the driver's queue
  task automatic queue_item(edge_req_t r);
    pending_q.insert(pending_q.size(), r);
  endtask

  function automatic logic [15:0] rnd_feat();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic settle();
    while (pending_q.size() != 0 || in_ch.valid || mean_q.size() != 0) @(posedge clk);
    // an edge item leaves no result; give it time to write back
    repeat (10) @(posedge clk);
  endtask

  task automatic write_active(logic [CFG_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    active_cnt = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // a random mix of edges and reads over nodes 0 to span-1
  task automatic rand_phase(int count, int span);
    int n;
    for (int i = 0; i < count; i++) begin
      n = $urandom_range(0, span - 1);
      if ($urandom_range(0, 6) == 0)
        queue_item(mk(REQ_READ, 8'(n), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom)));
      else
        queue_item(mk(REQ_ACC, 8'(n), rnd_feat(), rnd_feat(), rnd_feat(),
                      rnd_feat()));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] settings [5];
    errors = 0; cycles = 0; calm = 0;
    active_cnt = 256;
    for (int i = 0; i < NNODES; i++) begin
      deg_cnt[i] = '0;
      for (int c = 0; c < NLANES; c++) sum_row[i][c] = '0;
    end
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.req_type = 1'b0; in_ch.node = '0;
    in_ch.feat_0 = '0; in_ch.feat_1 = '0; in_ch.feat_2 = '0; in_ch.feat_3 = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: max active range, extremes, zero degree, inactive node
    write_active(9'd256);
    queue_item(mk(REQ_READ, 8'd0, '0, '0, '0, '0));         // degree zero
    queue_item(mk(REQ_ACC, 8'd255, 16'h7fff, 16'h8000, 16'h0001, 16'hffff));
    queue_item(mk(REQ_ACC, 8'd255, 16'h7fff, 16'h8000, 16'hffff, 16'hffff));
    queue_item(mk(REQ_ACC, 8'd255, 16'h0003, 16'hfffd, 16'h0000, 16'h5555));
    queue_item(mk(REQ_READ, 8'd255, '0, '0, '0, '0));
    queue_item(mk(REQ_READ, 8'd255, '0, '0, '0, '0));       // cleared row
    queue_item(mk(REQ_ACC, 8'd1, 16'h0007, 16'hfff9, 16'haaaa, 16'h5555));
    queue_item(mk(REQ_ACC, 8'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    queue_item(mk(REQ_READ, 8'd1, '1, '1, '1, '1));
    settle();
    write_active(9'd1);
    queue_item(mk(REQ_ACC, 8'd1, 16'h1234, 16'h1234, 16'h1234, 16'h1234));
    queue_item(mk(REQ_READ, 8'd1, '0, '0, '0, '0));         // inactive
    queue_item(mk(REQ_ACC, 8'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    queue_item(mk(REQ_READ, 8'd0, '0, '0, '0, '0));
    queue_item(mk(REQ_READ, 8'd200, '0, '0, '0, '0));
    settle();
    write_active(9'd0);
    queue_item(mk(REQ_ACC, 8'd0, 16'h0100, 16'h0100, 16'h0100, 16'h0100));
    queue_item(mk(REQ_READ, 8'd0, '0, '0, '0, '0));
    settle();

    // random phases over several settings; small spans keep rows busy
    settings = '{9'd256, 9'd3, 9'd17, 9'd255, 9'd511};
    for (int p = 0; p < 5; p++) begin
      write_active(settings[p]);
      if (p == 4) calm = 1;
      rand_phase(RAND_ITEMS / 5, (p == 1) ? 6 : ((p % 2) ? 24 : 256));
      // read back nodes 0 to 31
      for (int n = 0; n < 32; n++)
        queue_item(mk(REQ_READ, n[7:0], '0, '0, '0, '0));
      settle();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/gsma_pkg.sv
rtl/gsma_if.sv
rtl/gsma_ctrl.sv
rtl/gsma_dp.sv
rtl/graph_scatter_mean_aggregate.sv
tb/sv/gsma_tb_pkg.sv
tb/sv/gsma_tb_if.sv
tb/sv/graph_scatter_mean_aggregate_tb.sv
